// File: src/fwrv_pkg.sv
// Shared types and constants for the ordered queue with removal by value.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package fwrv_pkg;

   // Storage geometry of the queue.
   localparam int DEPTH = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes of the request.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   // Status codes of the response.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] key_value;
   } fwrv_req_type;

   typedef struct packed {
      logic signed [31:0] entry_value;
      logic [1:0]         status;
      logic               last;
   } fwrv_rsp_type;

   // Classified command that travels from the front to the back part.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_DUMP   = 2'd2
   } fwrv_cmd_kind_type;

   typedef struct packed {
      fwrv_cmd_kind_type  kind;
      logic signed [31:0] key;
   } fwrv_cmd_type;

endpackage

`default_nettype wire

// File: src/fwrv_front.sv
// Front part: takes request transfers, classifies them and drops unused codes.
// Depends on fwrv_pkg; feeds the command queue.
`timescale 1ns / 1ps
`default_nettype none

module fwrv_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  fwrv_pkg::fwrv_req_type req_data,
   output logic                   push,
   output fwrv_pkg::fwrv_cmd_type push_cmd,
   input  wire                    queue_full
);
   import fwrv_pkg::*;

   logic         front_valid_ff, front_valid_in;
   fwrv_cmd_type front_cmd_ff, front_cmd_in;
   logic         accept;
   logic         known_op;
   fwrv_cmd_kind_type kind;

   // The holding register stalls only while the queue is full.
   assign push     = front_valid_ff && !queue_full;
   assign push_cmd = front_cmd_ff;
   assign busy     = front_valid_ff && queue_full;
   assign accept   = start && !busy;

   // Map the operation code to a command; the unused code is discarded.
   always_comb begin
      known_op = 1'b1;
      kind     = CMD_INSERT;
      unique case (req_data.operation)
         OP_INSERT: kind = CMD_INSERT;
         OP_REMOVE: kind = CMD_REMOVE;
         OP_DUMP:   kind = CMD_DUMP;
         default:   known_op = 1'b0;
      endcase
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      front_cmd_in   = front_cmd_ff;
      if (push) begin
         front_valid_in = 1'b0;
      end
      if (accept && known_op) begin
         front_valid_in    = 1'b1;
         front_cmd_in.kind = kind;
         front_cmd_in.key  = req_data.key_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_cmd_ff <= front_cmd_in;
   end

endmodule

`default_nettype wire

// File: src/fwrv_cmd_queue.sv
// Short command queue that decouples the front part from the back part.
// Depends on fwrv_pkg for the command type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module fwrv_cmd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  fwrv_pkg::fwrv_cmd_type push_cmd,
   output logic                   full,
   input  wire                    pop,
   output logic                   pop_valid,
   output fwrv_pkg::fwrv_cmd_type pop_cmd
);
   import fwrv_pkg::*;

   fwrv_cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: src/fwrv_back.sv
// Back part: holds the entry cells and carries out insert, remove and dump.
// Depends on fwrv_pkg; pulls commands from the command queue.
`timescale 1ns / 1ps
`default_nettype none

module fwrv_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    cmd_valid,
   input  fwrv_pkg::fwrv_cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   output fwrv_pkg::fwrv_rsp_type rsp_data
);
   import fwrv_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SHIFT = 3'b010,
      S_DUMP  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic signed [31:0] cell_ff [DEPTH];
   logic signed [31:0] cell_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DEPTH-1:0]   match_ff, match_in;
   logic [IDX_W-1:0]   dump_idx_ff, dump_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fwrv_rsp_type       rsp_data_ff, rsp_data_in;
   logic [DEPTH-1:0]   shift_en;
   logic               is_full;
   logic               dump_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign dump_last = (CNT_W'(dump_idx_ff) == count_ff - CNT_W'(1));

   // Cells at and above the first match take their upper neighbor.
   // The prefix OR is built in log steps.
   always_comb begin
      shift_en = match_ff;
      for (int s = 1; s < DEPTH; s = s * 2) begin
         shift_en = shift_en | (shift_en << s);
      end
   end

   // Sequencer for the three commands.
   always_comb begin
      state_in     = state_ff;
      cell_in      = cell_ff;
      count_in     = count_ff;
      match_in     = match_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '{entry_value: '0, status: ST_OK, last: 1'b1};
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        cell_in[count_ff[IDX_W-1:0]] = cmd.key;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     // Compare every live cell against the key at once.
                     for (int i = 0; i < DEPTH; i++) begin
                        match_in[i] = (cell_ff[i] == cmd.key) && (CNT_W'(i) < count_ff);
                     end
                     state_in = S_SHIFT;
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        dump_idx_in = '0;
                        state_in    = S_DUMP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            rsp_valid_in = 1'b1;
            if (match_ff != '0) begin
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (shift_en[i]) begin
                     cell_in[i] = cell_ff[i + 1];
                  end
               end
               count_in = count_ff - 1'b1;
            end else begin
               rsp_data_in.status = ST_MISSING;
            end
            state_in = S_IDLE;
         end
         S_DUMP: begin
            // Stream one entry per cycle from head to tail.
            rsp_valid_in            = 1'b1;
            rsp_data_in.entry_value = cell_ff[dump_idx_ff];
            rsp_data_in.last        = dump_last;
            if (dump_last) begin
               state_in = S_IDLE;
            end else begin
               dump_idx_in = dump_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      match_ff    <= match_in;
      dump_idx_ff <= dump_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: src/fifo_with_remove_by_value.sv
// Ordered queue of signed 32-bit values with insert, remove by value and dump.
// Top level; instantiates fwrv_front, fwrv_cmd_queue and fwrv_back from fwrv_pkg.
// A request transfer happens on a clock edge with start high and busy low; the
// front part registers it, a two-entry command queue holds it and hands it to
// the back part, and the back part registers its response. A remove first
// compares all cells and then closes the gap in the shift state; a dump with
// entries starts from idle and streams them from head to tail in the dump state;
// an insert or an empty dump answers from idle. The back part takes a new command
// only while idle; the sequencer of the back part thus sets the sustained
// rate. Every response is a one-cycle strobe on rsp_valid that cannot be held off,
// so the receiver must take it when shown; the final response of each request
// carries last. Busy rises only when the command queue and the front register are
// both full. An unused operation code is accepted and produces no response.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_remove_by_value (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  fwrv_pkg::fwrv_req_type req_data,
   output logic                   rsp_valid,
   output fwrv_pkg::fwrv_rsp_type rsp_data
);
   import fwrv_pkg::*;

   logic         push;
   fwrv_cmd_type push_cmd;
   logic         queue_full;
   logic         cmd_pop;
   logic         cmd_valid;
   fwrv_cmd_type cmd;

   fwrv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   fwrv_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_cmd   (cmd)
   );

   fwrv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: src/fwrv_checker.sv
// Port-level checks for the queue with removal by value, bound to the top level.
// Depends on fwrv_pkg for the response type and status codes.
`timescale 1ns / 1ps
`default_nettype none

module fwrv_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    start,
   input wire                    busy,
   input fwrv_pkg::fwrv_rsp_type rsp_data,
   input wire                    rsp_valid
);
   import fwrv_pkg::*;

   // No response may follow directly out of reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   // Any status other than ok ends its request and carries no entry.
   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last && rsp_data.entry_value == '0)
      else $error("error status without last or with nonzero entry");

   // A dump streams without gaps until its last entry.
   a_dump_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a dump stream");

   // Backpressure only builds up after a request transfer.
   a_busy_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without a preceding transfer");

endmodule

bind fifo_with_remove_by_value fwrv_checker u_fwrv_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
